/* sv/swmc_pkg.sv */
`default_nettype none
package swmc_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;

  // fixed widths of the channel fields and the window size register
  localparam int SAMPLE_W = 32;
  localparam int COST_W   = 38;
  localparam int MEDIAN_W = 32;
  localparam int CFG_W    = 7;

  localparam int IDX_W = $clog2(WINDOW_MAX);
  localparam int CNT_W = IDX_W + 1;
  localparam int SUM_W = SAMPLE_BITS + IDX_W;

  typedef logic [SAMPLE_W-1:0]    sample_t;
  typedef logic [COST_W-1:0]      cost_t;
  typedef logic [MEDIAN_W-1:0]    median_t;
  typedef logic [CFG_W-1:0]       cfg_t;
  typedef logic [SAMPLE_BITS-1:0] val_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [SUM_W-1:0]       sum_t;

endpackage
`default_nettype wire

/* sv/swmc_stream_if.sv */
`default_nettype none
interface swmc_in_if import swmc_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface swmc_out_if import swmc_pkg::*;;
  logic    valid;
  logic    ready;
  cost_t   cost;
  median_t median;

  modport source (output valid, output cost, output median, input ready);
  modport sink (input valid, input cost, input median, output ready);
endinterface
`default_nettype wire

/* sv/sliding_window_median_cost_core.sv */
// Sliding-window median cost.
// in_if carries one unsigned sample per request. out_if carries the lower
// median of the last k samples and the sum of absolute differences of the
// window to that median. cfg_we/cfg_data set k (0 acts as 1, values above
// the window capacity act as the capacity) and empty the window.
// The first k-1 samples after a window size write only fill the window;
// every sample after that gives one result.
// Throughput: one sample per cycle while in_if.ready is high; the sorted
// cell row drops the oldest sample and inserts the new one in one update,
// and the lower and total sums are updated in the same step.
// A finished result waits in a pending stage and then in the output
// register; the input is taken while the output register holds a result,
// and in_if.ready falls only when both hold one and out_if.ready is low.
// Reset: rst_n (synchronous) empties the window, drops any pending result
// and sets k to 1. The sample store needs no clearing pass.
`default_nettype none
module sliding_window_median_cost_core import swmc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  swmc_in_if.sink     in_if,
  swmc_out_if.source  out_if,
  input  wire logic   cfg_we,
  input  wire cfg_t   cfg_data
);

  // sorted cell row: value and ring slot of each held sample
  val_t    val_r [WINDOW_MAX];
  idx_t    tag_r [WINDOW_MAX];
  cnt_t    fill_r;
  idx_t    oldest_r;
  sum_t    lower_r;
  sum_t    total_r;
  cfg_t    k_r;
  logic    pend_r;
  logic    out_valid_r;
  cost_t   cost_r;
  median_t median_r;

  val_t    val_nxt [WINDOW_MAX];
  idx_t    tag_nxt [WINDOW_MAX];
  cnt_t    fill_nxt;
  idx_t    oldest_nxt;
  sum_t    lower_nxt;
  sum_t    total_nxt;
  cost_t   cost_nxt;

  val_t    b_val [WINDOW_MAX];
  idx_t    b_tag [WINDOW_MAX];
  logic    keep_lo [WINDOW_MAX];
  logic    le_s [WINDOW_MAX];
  logic    le_b [WINDOW_MAX];

  cnt_t    k_act;
  cnt_t    lo_n;
  idx_t    lo_idx;
  idx_t    up_idx;
  idx_t    last_slot;
  cnt_t    mid_cnt;
  logic    full;
  val_t    s;
  val_t    old_val;
  idx_t    new_tag;
  sum_t    rem_sub;
  sum_t    rem_add;
  sum_t    ins_add;
  sum_t    ins_sub;
  val_t    med;

  logic    move;
  logic    in_ready;
  logic    accept;

  always_comb begin
    if (k_r == '0) begin
      k_act = cnt_t'(1);
    end else if (int'(k_r) > WINDOW_MAX) begin
      k_act = cnt_t'(WINDOW_MAX);
    end else begin
      k_act = cnt_t'(k_r);
    end
    lo_n      = (k_act + cnt_t'(1)) >> 1;
    lo_idx    = idx_t'(lo_n - cnt_t'(1));
    up_idx    = lo_n[IDX_W-1:0];
    last_slot = idx_t'(k_act - cnt_t'(1));
    full      = (fill_r == k_act);
    s         = in_if.sample[SAMPLE_BITS-1:0];
    mid_cnt   = full ? fill_r - cnt_t'(1) : fill_r;
    new_tag   = full ? oldest_r : fill_r[IDX_W-1:0];

    // value leaving the window: the cell tagged with the oldest ring slot
    old_val = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (full && tag_r[i] == oldest_r && cnt_t'(i) < fill_r) begin
        old_val = val_r[i];
      end
    end

    // equal values sit in arrival order, so the first copy is the oldest
    for (int i = 0; i < WINDOW_MAX; i++) begin
      keep_lo[i] = !full || (cnt_t'(i) < fill_r && val_r[i] < old_val);
      le_s[i]    = val_r[i] <= s;
    end

    // close the gap left by the dropped sample
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (keep_lo[i] || i == WINDOW_MAX - 1) begin
        b_val[i] = val_r[i];
        b_tag[i] = tag_r[i];
        le_b[i]  = (cnt_t'(i) < mid_cnt) && le_s[i];
      end else begin
        b_val[i] = val_r[(i == WINDOW_MAX - 1) ? i : i + 1];
        b_tag[i] = tag_r[(i == WINDOW_MAX - 1) ? i : i + 1];
        le_b[i]  = (cnt_t'(i) < mid_cnt) && le_s[(i == WINDOW_MAX - 1) ? i : i + 1];
      end
    end

    // open a slot behind all values not above the new sample
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (le_b[i]) begin
        val_nxt[i] = b_val[i];
        tag_nxt[i] = b_tag[i];
      end else if (i == 0 || le_b[(i == 0) ? 0 : i - 1]) begin
        val_nxt[i] = s;
        tag_nxt[i] = new_tag;
      end else begin
        val_nxt[i] = b_val[(i == 0) ? 0 : i - 1];
        tag_nxt[i] = b_tag[(i == 0) ? 0 : i - 1];
      end
    end

    // lower sum covers the first min(count, lower half) sorted samples
    rem_sub = '0;
    rem_add = '0;
    if (full && !keep_lo[lo_idx]) begin
      rem_sub = sum_t'(old_val);
      if (fill_r > lo_n) begin
        rem_add = sum_t'(val_r[up_idx]);
      end
    end
    ins_add = '0;
    ins_sub = '0;
    if (mid_cnt < lo_n) begin
      ins_add = sum_t'(s);
    end else if (!le_b[lo_idx]) begin
      ins_add = sum_t'(s);
      ins_sub = sum_t'(b_val[lo_idx]);
    end
    lower_nxt = lower_r - rem_sub + rem_add + ins_add - ins_sub;
    total_nxt = total_r - (full ? sum_t'(old_val) : sum_t'(0)) + sum_t'(s);

    fill_nxt   = full ? fill_r : fill_r + cnt_t'(1);
    oldest_nxt = '0;
    if (full && oldest_r != last_slot) begin
      oldest_nxt = oldest_r + idx_t'(1);
    end

    // odd window: median counts once more on the lower side
    med      = val_r[lo_idx];
    cost_nxt = cost_t'(total_r - (lower_r << 1) + (k_act[0] ? sum_t'(med) : sum_t'(0)));
  end

  assign move     = pend_r && (!out_valid_r || out_if.ready);
  assign in_ready = !pend_r || !out_valid_r || out_if.ready;
  assign accept   = in_if.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      oldest_r    <= '0;
      lower_r     <= '0;
      total_r     <= '0;
      k_r         <= cfg_t'(1);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        k_r      <= cfg_data;
        fill_r   <= '0;
        oldest_r <= '0;
        lower_r  <= '0;
        total_r  <= '0;
      end else if (accept) begin
        fill_r   <= fill_nxt;
        oldest_r <= oldest_nxt;
        lower_r  <= lower_nxt;
        total_r  <= total_nxt;
      end

      if (accept) begin
        pend_r <= (fill_nxt == k_act);
      end else if (move) begin
        pend_r <= 1'b0;
      end

      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_r <= val_nxt;
      tag_r <= tag_nxt;
    end
    // state registers still hold the pending request's window here
    if (move) begin
      cost_r   <= cost_nxt;
      median_r <= median_t'(med);
    end
  end

  assign in_if.ready   = in_ready;
  assign out_if.valid  = out_valid_r;
  assign out_if.cost   = cost_r;
  assign out_if.median = median_r;

endmodule
`default_nettype wire

/* sv/swmc_checker.sv */
`default_nettype none
module swmc_checker import swmc_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  input wire logic  in_valid,
  input wire logic  in_ready,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire cost_t out_cost,
  input wire logic  cfg_we,
  input wire cfg_t  cfg_data
);

  logic unit_win_r;

  // track whether the window size is one (k written as 0 or 1)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_win_r <= 1'b1;
    end else if (cfg_we) begin
      unit_win_r <= (cfg_data == cfg_t'(0)) || (cfg_data == cfg_t'(1));
    end
  end

  a_unit_window_zero_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && unit_win_r |-> out_cost == '0)
    else $error("single-sample window gave non-zero cost");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a request two cycles earlier");

  a_ready_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while the output side was ready");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cost))
    else $error("stalled result changed or vanished");

endmodule

bind sliding_window_median_cost_core swmc_checker u_swmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_cost  (out_if.cost),
  .cfg_we    (cfg_we),
  .cfg_data  (cfg_data)
);
`default_nettype wire
